### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge, off during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");

`endif

### rtl/omuf_pkg.sv
`default_nettype none
package omuf_pkg;
	localparam int MAX_SURVIVORS  = 4096;
	localparam int TABLE_SLOTS    = 65536;
	localparam int MAX_STEP_LIMIT = 1023;
	localparam int SURV_BITS      = $clog2(MAX_SURVIVORS);
	localparam int SLOT_BITS      = $clog2(TABLE_SLOTS);
	localparam int STEP_W         = 10;
	localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;

	localparam logic CFG_STEP_LIMIT = 1'b0;
	localparam logic CFG_SEED_BITS  = 1'b1;

	typedef struct packed {
		logic [9:0] step_limit;
		logic [5:0] seed_bits;
	} cfg_t;

	typedef struct packed {
		logic [63:0] seed;
		logic [31:0] exit_time;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_out_t;

	typedef struct packed {
		logic clearing;
		logic pop;
	} back_status_t;

	typedef struct packed {
		logic [63:0] earlier_seed;
		logic [63:0] later_seed;
		logic [9:0]  earlier_step;
		logic [9:0]  later_step;
		logic [6:0]  low_bit_agreement;
		logic [9:0]  prefix_length;
		logic [16:0] earlier_shift_sum;
		logic [16:0] later_shift_sum;
		logic [31:0] earlier_exit;
		logic [31:0] later_exit;
		logic        overflow;
	} result_t;

	typedef struct packed {
		logic                 used;
		logic [63:0]          hi;
		logic [63:0]          lo;
		logic [SURV_BITS-1:0] owner;
		logic [STEP_W-1:0]    step;
	} slot_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_ALLOC, ST_HASH, ST_PRD, ST_PCHK, ST_STORE, ST_SWAIT,
		ST_FRD, ST_FCHK, ST_FGP, ST_LINK, ST_XRD, ST_XCHK, ST_RGO, ST_RWAIT, ST_EMIT
	} back_state_t;
endpackage
`default_nettype wire

### rtl/orbit_merge_union_find_unit.sv
`default_nettype none
// Orbit merge unit. Seed records enter as command transactions: a record is
// taken at a rising edge with start high and busy low. Records that are not
// survivors (exit time not above step_limit, or seed not below 2^seed_bits)
// are discarded at the front with no result. Survivors wait in a two-entry
// queue until the back end is free; busy rises when that queue is full and
// while the table is cleared. The back end walks each survivor's odd-only
// 3v+1 orbit through a 65536-slot hash table. Each orbit step hashes the
// value, reads and checks probed slots in turn, stores the value and waits
// for the halving unit. A meeting runs two path-halving root finds (parent
// reads and compression writes), then a replay of both orbits lasting
// max(i,j) rounds.
// At most one result per record appears on the result ports for exactly one
// cycle with result_valid high; the receiver cannot hold it off, so the
// ports simply show it once. After reset the table is cleared one slot per
// cycle with busy high; configuration writes (cfg_we, cfg_index, cfg_wdata)
// are taken at any time but are meant for idle periods.
module orbit_merge_union_find_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [63:0] seed,
	input  wire logic [31:0] exit_time,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [9:0]  cfg_wdata,
	output logic             result_valid,
	output logic      [63:0] earlier_seed,
	output logic      [63:0] later_seed,
	output logic      [9:0]  earlier_step,
	output logic      [9:0]  later_step,
	output logic      [6:0]  low_bit_agreement,
	output logic      [9:0]  prefix_length,
	output logic      [16:0] earlier_shift_sum,
	output logic      [16:0] later_shift_sum,
	output logic      [31:0] earlier_exit,
	output logic      [31:0] later_exit,
	output logic             overflow
);
	import omuf_pkg::*;

	cfg_t         cfg;
	queue_out_t   qout;
	back_status_t bstat;
	result_t      res;

	// Front end: configuration, survivor test and the hand-off queue.
	omuf_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .seed(seed), .exit_time(exit_time),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.bstat(bstat), .busy(busy), .cfg(cfg), .qout(qout)
	);

	// Back end: table walk, union-find and feature replay.
	omuf_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .qin(qout), .bstat(bstat),
		.res_valid(result_valid), .res(res)
	);

	assign earlier_seed      = res.earlier_seed;
	assign later_seed        = res.later_seed;
	assign earlier_step      = res.earlier_step;
	assign later_step        = res.later_step;
	assign low_bit_agreement = res.low_bit_agreement;
	assign prefix_length     = res.prefix_length;
	assign earlier_shift_sum = res.earlier_shift_sum;
	assign later_shift_sum   = res.later_shift_sum;
	assign earlier_exit      = res.earlier_exit;
	assign later_exit        = res.later_exit;
	assign overflow          = res.overflow;
endmodule
`default_nettype wire

### rtl/omuf_ram.sv
`default_nettype none
module omuf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

### rtl/omuf_orbit_step.sv
`default_nettype none
module omuf_orbit_step (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [127:0] v_in,
	output logic              busy,
	output logic      [127:0] v_out,
	output logic      [7:0]   d
);
	logic         busy_q;
	logic [127:0] n_q;
	logic [7:0]   d_q;
	logic [3:0]   tz;

	// Trailing zeros of a nonzero 16-bit chunk.
	function automatic logic [3:0] tz16(input logic [15:0] w);
		logic [3:0] n;
		n = 4'd15;
		for (int k = 15; k >= 0; k--) begin
			if (w[k]) begin
				n = 4'(k);
			end
		end
		return n;
	endfunction

	assign tz = tz16(n_q[15:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (n_q == '0 || n_q[15:0] != '0)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= {v_in[126:0], 1'b0} + v_in + 128'd1;
			d_q <= '0;
		end else if (busy_q) begin
			if (n_q == '0) begin
				d_q <= 8'd128;
			end else if (n_q[15:0] == '0) begin
				n_q <= n_q >> 16;
				d_q <= d_q + 8'd16;
			end else begin
				n_q <= n_q >> tz;
				d_q <= d_q + 8'(tz);
			end
		end
	end

	assign busy  = busy_q;
	assign v_out = n_q;
	assign d     = d_q;
endmodule
`default_nettype wire

### rtl/omuf_front.sv
`default_nettype none
module omuf_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [63:0]           seed,
	input  wire logic [31:0]           exit_time,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [9:0]            cfg_wdata,
	input  wire omuf_pkg::back_status_t bstat,
	output logic                       busy,
	output omuf_pkg::cfg_t             cfg,
	output omuf_pkg::queue_out_t       qout
);
	import omuf_pkg::*;

	cfg_t       cfg_q;
	item_t      fifo_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       accept, survivor, push;

	assign busy     = bstat.clearing || cnt_q == 2'd2;
	assign accept   = start && !busy;
	assign survivor = exit_time > 32'(cfg_q.step_limit) && (seed >> cfg_q.seed_bits) == '0;
	assign push     = accept && survivor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_limit <= 10'd32;
			cfg_q.seed_bits  <= 6'd40;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_STEP_LIMIT: cfg_q.step_limit <= cfg_wdata;
					CFG_SEED_BITS:  cfg_q.seed_bits  <= cfg_wdata[5:0];
					default: ;
				endcase
			end
			if (push) begin
				wr_q <= !wr_q;
			end
			if (bstat.pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(bstat.pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= '{seed: seed, exit_time: exit_time};
		end
	end

	assign cfg        = cfg_q;
	assign qout.valid = cnt_q != '0;
	assign qout.item  = fifo_q[rd_q];
endmodule
`default_nettype wire

### rtl/omuf_back.sv
`default_nettype none
module omuf_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire omuf_pkg::cfg_t       cfg,
	input  wire omuf_pkg::queue_out_t qin,
	output omuf_pkg::back_status_t    bstat,
	output logic                      res_valid,
	output omuf_pkg::result_t         res
);
	import omuf_pkg::*;

	localparam int SUM_W = SLOT_BITS + 2;
	localparam int SRV_W = 96;

	back_state_t state_q, state_d;

	logic [SLOT_BITS-1:0] clr_q, pos_q;
	logic [SURV_BITS:0]   count_q;
	logic [SLOT_BITS:0]   fill_q;
	logic [63:0]          seed_q, x_q;
	logic [31:0]          ex_q, eex_q;
	logic [SURV_BITS-1:0] id_q, owner_q, a_q, ra_q;
	logic [127:0]         v_q, va_q, vb_q;
	logic [STEP_W-1:0]    t_q, i_q, s_q, pre_q;
	logic [16:0]          sx_q, sy_q;
	logic                 fphase_q, pre_set_q;
	logic                 res_valid_q;
	result_t              res_q;

	logic [STEP_W-1:0] steps, top, da, db;
	logic              ovf, run_a, run_b, match;

	logic                 s_we, p_we, v_we;
	logic [SLOT_BITS-1:0] s_addr;
	logic [SURV_BITS-1:0] p_addr, p_wdata, p_rdata, v_addr;
	slot_t                s_wdata, s_rdata;
	logic [SRV_W-1:0]     v_wdata, v_rdata;

	logic         u0_start, u1_start, u0_busy, u1_busy;
	logic [127:0] u0_vin, u0_vout, u1_vout;
	logic [7:0]   u0_d, u1_d;

	function automatic logic [6:0] tz64(input logic [63:0] w);
		logic [6:0] n;
		n = 7'd64;
		for (int k = 63; k >= 0; k--) begin
			if (w[k]) begin
				n = 7'(k);
			end
		end
		return n;
	endfunction

	function automatic logic [SLOT_BITS-1:0] slot_hash(input logic [127:0] v);
		logic [SLOT_BITS-1:0]   x;
		logic [2*SLOT_BITS-1:0] p;
		x = v[SLOT_BITS-1:0] ^ v[64 +: SLOT_BITS];
		p = {{SLOT_BITS{1'b0}}, x} * {{SLOT_BITS{1'b0}}, HASH_MUL[SLOT_BITS-1:0]};
		return p[SLOT_BITS-1:0];
	endfunction

	omuf_ram #(.WIDTH($bits(slot_t)), .DEPTH(TABLE_SLOTS)) u_slots (
		.clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
	);
	omuf_ram #(.WIDTH(SURV_BITS), .DEPTH(MAX_SURVIVORS)) u_parent (
		.clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata)
	);
	omuf_ram #(.WIDTH(SRV_W), .DEPTH(MAX_SURVIVORS)) u_surv (
		.clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata)
	);
	omuf_orbit_step u_step0 (
		.clk(clk), .arst_n(arst_n), .start(u0_start), .v_in(u0_vin),
		.busy(u0_busy), .v_out(u0_vout), .d(u0_d)
	);
	omuf_orbit_step u_step1 (
		.clk(clk), .arst_n(arst_n), .start(u1_start), .v_in(vb_q),
		.busy(u1_busy), .v_out(u1_vout), .d(u1_d)
	);

	assign steps = (cfg.step_limit > STEP_W'(MAX_STEP_LIMIT)) ? STEP_W'(MAX_STEP_LIMIT)
	                                                          : cfg.step_limit;
	assign ovf   = count_q >= (SURV_BITS+1)'(MAX_SURVIVORS) ||
	               SUM_W'(fill_q) + SUM_W'(steps) > SUM_W'(TABLE_SLOTS);
	assign match = s_rdata.hi == v_q[127:64] && s_rdata.lo == v_q[63:0];
	assign top   = (i_q > t_q) ? i_q : t_q;
	assign run_a = s_q < i_q;
	assign run_b = s_q < t_q;
	assign da    = run_a ? STEP_W'(u0_d) : '0;
	assign db    = run_b ? STEP_W'(u1_d) : '0;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == SLOT_BITS'(TABLE_SLOTS - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (qin.valid) state_d = ST_ALLOC;
			ST_ALLOC: state_d = (ovf || steps == '0) ? ST_IDLE : ST_HASH;
			ST_HASH:  state_d = ST_PRD;
			ST_PRD:   state_d = ST_PCHK;
			ST_PCHK: begin
				if (!s_rdata.used) state_d = ST_STORE;
				else if (match) state_d = ST_FRD;
				else state_d = ST_PRD;
			end
			ST_STORE: state_d = ST_SWAIT;
			ST_SWAIT: begin
				if (!u0_busy) begin
					state_d = ((STEP_W+1)'(t_q) + 1'b1 == (STEP_W+1)'(steps)) ? ST_IDLE
					                                                          : ST_HASH;
				end
			end
			ST_FRD: state_d = ST_FCHK;
			ST_FCHK: begin
				if (p_rdata != a_q) state_d = ST_FGP;
				else if (!fphase_q) state_d = ST_FRD;
				else state_d = (ra_q == a_q) ? ST_IDLE : ST_LINK;
			end
			ST_FGP:  state_d = ST_FRD;
			ST_LINK: state_d = ST_XRD;
			ST_XRD:  state_d = ST_XCHK;
			ST_XCHK: state_d = (top == '0) ? ST_EMIT : ST_RGO;
			ST_RGO:  state_d = ST_RWAIT;
			ST_RWAIT: begin
				if (!u0_busy && !u1_busy) begin
					state_d = ((STEP_W+1)'(s_q) + 1'b1 == (STEP_W+1)'(top)) ? ST_EMIT
					                                                        : ST_RGO;
				end
			end
			ST_EMIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory ports, unit starts and queue pop.
	always_comb begin
		s_we     = 1'b0;
		s_addr   = pos_q;
		s_wdata  = '{used: 1'b1, hi: v_q[127:64], lo: v_q[63:0], owner: id_q, step: t_q};
		p_we     = 1'b0;
		p_addr   = a_q;
		p_wdata  = p_rdata;
		v_we     = 1'b0;
		v_addr   = owner_q;
		v_wdata  = {seed_q, ex_q};
		u0_start = 1'b0;
		u0_vin   = va_q;
		u1_start = 1'b0;
		bstat.clearing = state_q == ST_CLEAR;
		bstat.pop      = state_q == ST_IDLE && qin.valid;
		case (state_q)
			ST_CLEAR: begin
				s_we    = 1'b1;
				s_addr  = clr_q;
				s_wdata = '0;
			end
			ST_ALLOC: begin
				p_we    = !ovf;
				p_addr  = count_q[SURV_BITS-1:0];
				p_wdata = count_q[SURV_BITS-1:0];
				v_we    = !ovf;
				v_addr  = count_q[SURV_BITS-1:0];
			end
			ST_STORE: begin
				s_we     = 1'b1;
				u0_start = 1'b1;
				u0_vin   = v_q;
			end
			ST_FCHK: p_addr = p_rdata;
			ST_FGP:  p_we = 1'b1;
			ST_LINK: begin
				p_we    = 1'b1;
				p_wdata = ra_q;
			end
			ST_RGO: begin
				u0_start = run_a;
				u1_start = run_b;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			fill_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= (state_q == ST_ALLOC && ovf) || state_q == ST_EMIT;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_ALLOC && !ovf) count_q <= count_q + 1'b1;
			if (state_q == ST_STORE) fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				seed_q <= qin.item.seed;
				ex_q   <= qin.item.exit_time;
			end
			ST_ALLOC: begin
				id_q  <= count_q[SURV_BITS-1:0];
				v_q   <= {64'd0, seed_q};
				t_q   <= '0;
				res_q <= '{overflow: 1'b1, default: '0};
			end
			ST_HASH: pos_q <= slot_hash(v_q);
			ST_PCHK: begin
				// The probe moves on only past a used slot holding another value.
				if (s_rdata.used && !match) begin
					pos_q <= pos_q + 1'b1;
				end
				owner_q  <= s_rdata.owner;
				a_q      <= s_rdata.owner;
				i_q      <= s_rdata.step;
				fphase_q <= 1'b0;
			end
			ST_SWAIT: begin
				if (!u0_busy) begin
					v_q <= u0_vout;
					t_q <= t_q + 1'b1;
				end
			end
			ST_FCHK: begin
				if (p_rdata == a_q && !fphase_q) begin
					ra_q     <= a_q;
					a_q      <= id_q;
					fphase_q <= 1'b1;
				end
			end
			ST_FGP: a_q <= p_rdata;
			ST_XCHK: begin
				x_q       <= v_rdata[95:32];
				eex_q     <= v_rdata[31:0];
				va_q      <= {64'd0, v_rdata[95:32]};
				vb_q      <= {64'd0, seed_q};
				s_q       <= '0;
				sx_q      <= '0;
				sy_q      <= '0;
				pre_set_q <= 1'b0;
			end
			ST_RWAIT: begin
				if (!u0_busy && !u1_busy) begin
					if (run_a) va_q <= u0_vout;
					if (run_b) vb_q <= u1_vout;
					sx_q <= sx_q + 17'(da);
					sy_q <= sy_q + 17'(db);
					if (!pre_set_q && (!run_a || !run_b || da != db)) begin
						pre_q     <= s_q;
						pre_set_q <= 1'b1;
					end
					s_q <= s_q + 1'b1;
				end
			end
			ST_EMIT: begin
				res_q.earlier_seed      <= x_q;
				res_q.later_seed        <= seed_q;
				res_q.earlier_step      <= i_q;
				res_q.later_step        <= t_q;
				res_q.low_bit_agreement <= tz64(x_q ^ seed_q);
				res_q.prefix_length     <= pre_set_q ? pre_q : ((i_q < t_q) ? i_q : t_q);
				res_q.earlier_shift_sum <= sx_q;
				res_q.later_shift_sum   <= sy_q;
				res_q.earlier_exit      <= eex_q;
				res_q.later_exit        <= ex_q;
				res_q.overflow          <= 1'b0;
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;
endmodule
`default_nettype wire

### rtl/omuf_checker.sv
`default_nettype none
`include "assert_macros.svh"
module omuf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic [63:0] earlier_seed,
	input wire logic [63:0] later_seed,
	input wire logic [9:0]  earlier_step,
	input wire logic [9:0]  later_step,
	input wire logic [6:0]  low_bit_agreement,
	input wire logic [9:0]  prefix_length,
	input wire logic [16:0] earlier_shift_sum,
	input wire logic [16:0] later_shift_sum,
	input wire logic [31:0] earlier_exit,
	input wire logic [31:0] later_exit,
	input wire logic        overflow
);
	// A dropped record carries no features.
	`ASSERT_IMPL(a_ovf_zero, clk, arst_n, result_valid && overflow, earlier_seed == '0 && later_seed == '0 && earlier_step == '0 && later_step == '0 && prefix_length == '0 && earlier_shift_sum == '0 && later_shift_sum == '0 && earlier_exit == '0 && later_exit == '0 && low_bit_agreement == '0)
	// Equal seeds agree in every low bit.
	`ASSERT_IMPL(a_lowbits, clk, arst_n, result_valid && !overflow, (earlier_seed == later_seed) == (low_bit_agreement == 7'd64))
	// The common prefix never runs past the shorter orbit.
	`ASSERT_IMPL(a_prefix, clk, arst_n, result_valid && !overflow, prefix_length <= earlier_step && prefix_length <= later_step)
	// Results never come in consecutive cycles.
	`ASSERT_NEXT(a_spacing, clk, arst_n, result_valid, !result_valid)
endmodule

bind orbit_merge_union_find_unit omuf_checker u_omuf_checker (.*);
`default_nettype wire
